// File: src/osfe_pkg.sv
// Shared types and constants for the object shape feature extractor.
// No dependencies.
package osfe_pkg;

  localparam int unsigned THIN_K = 51470;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  typedef enum logic [2:0] {
    CFG_BLUE   = 3'd0,
    CFG_GREEN  = 3'd1,
    CFG_RED    = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_t;

  // Frame totals handed from the pixel front end to the divider back end.
  typedef struct packed {
    logic [20:0] area;
    logic [29:0] x_sum;
    logic [29:0] y_sum;
    logic [20:0] perim;
    logic [9:0]  x_min;
    logic [9:0]  x_max;
    logic [9:0]  y_min;
    logic [9:0]  y_max;
  } frame_sum_t;

  // Unsigned restoring divider step: compare and subtract; the caller shifts the remainder in.
  function automatic logic [63:0] div_step(input logic [63:0] rem_in,
                                           input logic [63:0] den);
    div_step = (rem_in >= den) ? rem_in - den : rem_in;
  endfunction

endpackage

// File: src/osfe_front.sv
// Pixel front end: match, line stores, window, accumulators.
// Depends on osfe_pkg.
module osfe_front import osfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             px_valid,
  output logic             px_ready,
  input  logic [7:0]       px_blue,
  input  logic [7:0]       px_green,
  input  logic [7:0]       px_red,
  input  logic [7:0]       tgt_blue,
  input  logic [7:0]       tgt_green,
  input  logic [7:0]       tgt_red,
  input  logic [10:0]      cfg_w,
  input  logic [10:0]      cfg_h,
  output logic             sum_valid,
  input  logic             sum_ready,
  output frame_sum_t       sum_data
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic [9:0]  col_r, row_r;
  logic [20:0] area_r, perim_r;
  logic [29:0] xs_r, ys_r;
  logic [9:0]  xmin_r, xmax_r, ymin_r, ymax_r;
  logic [2:0]  w0_r, w1_r, w2_r;
  logic        line_old [MAX_WIDTH];
  logic        line_new [MAX_WIDTH];
  logic        old_q_r, new_q_r;
  logic        out_v_r;
  frame_sum_t  out_r;

  logic [11:0] w_eff, h_eff;
  logic        last_col, last_row, match, ob, nb, fire;
  logic [XW-1:0] xi, xi_nxt;
  logic [2:0]  n0, n1, n2;
  logic [2:0]  add;

  function automatic logic edge_c(input logic [2:0] a, input logic [2:0] b,
                                  input logic [2:0] c);
    edge_c = b[1] & ~(&a & b[0] & b[2] & (&c));
  endfunction

  always_comb begin
    w_eff = (cfg_w == 11'd0) ? 12'd1 :
            ({1'b0, cfg_w} > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : {1'b0, cfg_w};
    h_eff = (cfg_h == 11'd0) ? 12'd1 :
            ({1'b0, cfg_h} > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : {1'b0, cfg_h};
    last_col = {2'b0, col_r} >= w_eff - 12'd1;
    last_row = {2'b0, row_r} >= h_eff - 12'd1;
    xi = ({2'b0, col_r} < 12'(MAX_WIDTH)) ? col_r[XW-1:0] : XW'(MAX_WIDTH - 1);
    xi_nxt = last_col ? '0 : xi + XW'(1);
    match = (px_blue == tgt_blue) && (px_green == tgt_green) && (px_red == tgt_red);
    ob = (row_r >= 10'd2) ? old_q_r : 1'b0;
    nb = (row_r >= 10'd1) ? new_q_r : 1'b0;
    // window rows: bit2 = x, bit1 = x-1, bit0 = x-2
    if (col_r == 10'd0) begin
      n0 = {ob, 2'b0}; n1 = {nb, 2'b0}; n2 = {match, 2'b0};
    end else begin
      n0 = {ob, w0_r[2:1]}; n1 = {nb, w1_r[2:1]}; n2 = {match, w2_r[2:1]};
    end
    add = 3'd0;
    if (row_r >= 10'd1) begin
      if (col_r >= 10'd1) add = add + 3'(edge_c(n0, n1, n2));
      if (last_col) add = add + 3'(edge_c({1'b0, n0[2:1]}, {1'b0, n1[2:1]},
                                         {1'b0, n2[2:1]}));
    end
    if (last_row) begin
      if (col_r >= 10'd1) add = add + 3'(edge_c(n1, n2, 3'b0));
      if (last_col) add = add + 3'(edge_c({1'b0, n1[2:1]}, {1'b0, n2[2:1]}, 3'b0));
    end
  end

  assign px_ready  = !out_v_r;
  assign fire      = px_valid && px_ready;
  assign sum_valid = out_v_r;
  assign sum_data  = out_r;

  // Read one pixel ahead; forward the write when the next column is the same.
  always_ff @(posedge clk) begin
    if (fire) begin
      line_old[xi] <= nb;
      line_new[xi] <= match;
      if (xi_nxt == xi) begin
        old_q_r <= nb;
        new_q_r <= match;
      end else begin
        old_q_r <= line_old[xi_nxt];
        new_q_r <= line_new[xi_nxt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; area_r <= '0; perim_r <= '0;
      xs_r <= '0; ys_r <= '0; xmin_r <= '1; xmax_r <= '0;
      ymin_r <= '1; ymax_r <= '0; w0_r <= '0; w1_r <= '0; w2_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && sum_ready) out_v_r <= 1'b0;
      if (fire) begin
        logic [20:0] a_n, p_n;
        logic [29:0] xs_n, ys_n;
        logic [9:0]  x0, x1, y0, y1;
        a_n = area_r; xs_n = xs_r; ys_n = ys_r;
        x0 = xmin_r; x1 = xmax_r; y0 = ymin_r; y1 = ymax_r;
        p_n = perim_r + 21'(add);
        if (match) begin
          a_n = area_r + 21'd1;
          xs_n = xs_r + 30'(col_r);
          ys_n = ys_r + 30'(row_r);
          if (col_r < xmin_r) x0 = col_r;
          if (col_r > xmax_r) x1 = col_r;
          if (row_r < ymin_r) y0 = row_r;
          if (row_r > ymax_r) y1 = row_r;
        end
        if (last_col && last_row) begin
          out_r <= '{a_n, xs_n, ys_n, p_n, x0, x1, y0, y1};
          out_v_r <= 1'b1;
          col_r <= '0; row_r <= '0; area_r <= '0; perim_r <= '0;
          xs_r <= '0; ys_r <= '0; xmin_r <= '1; xmax_r <= '0;
          ymin_r <= '1; ymax_r <= '0; w0_r <= '0; w1_r <= '0; w2_r <= '0;
        end else begin
          w0_r <= n0; w1_r <= n1; w2_r <= n2;
          area_r <= a_n; perim_r <= p_n; xs_r <= xs_n; ys_r <= ys_n;
          xmin_r <= x0; xmax_r <= x1; ymin_r <= y0; ymax_r <= y1;
          if (last_col) begin
            col_r <= '0;
            row_r <= row_r + 10'd1;
          end else begin
            col_r <= col_r + 10'd1;
          end
        end
      end
    end
  end

endmodule

// File: src/osfe_queue.sv
// Two-entry queue of frame totals between front end and back end.
// Depends on osfe_pkg.
module osfe_queue import osfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  frame_sum_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output frame_sum_t rd_data
);

  frame_sum_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

// File: src/osfe_back.sv
// Back end: serial divisions for centroid, aspect and thinness.
// Depends on osfe_pkg.
module osfe_back import osfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  frame_sum_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_object_area,
  output logic [9:0]  out_centroid_x,
  output logic [9:0]  out_centroid_y,
  output logic [20:0] out_perimeter_count,
  output logic [9:0]  out_box_x_min,
  output logic [9:0]  out_box_x_max,
  output logic [9:0]  out_box_y_min,
  output logic [9:0]  out_box_y_max,
  output logic [18:0] out_aspect_q8,
  output logic [15:0] out_thinness_q12,
  output logic        out_object_empty
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_NEXT, S_OUT
  } state_t;

  state_t      st_r;
  frame_sum_t  f_r;
  logic [1:0]  op_r;
  logic [5:0]  cnt_r;
  logic [63:0] num_r, den_r, rem_r, q_r;
  logic [41:0] p2_r;
  logic [36:0] an_r;
  logic [9:0]  cx_r, cy_r;
  logic [18:0] asp_r;
  logic [15:0] thin_r;
  logic [63:0] rem_sh;

  assign in_ready  = st_r == S_IDLE;
  assign out_valid = st_r == S_OUT;
  assign rem_sh    = {rem_r[62:0], num_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          f_r <= in_data;
          cx_r <= '0; cy_r <= '0; asp_r <= '0; thin_r <= '0;
          st_r <= (in_data.area == 21'd0) ? S_OUT : S_MUL;
        end
        S_MUL: begin
          p2_r <= 42'(f_r.perim) * 42'(f_r.perim);
          an_r <= 37'(f_r.area) * 37'(THIN_K);
          op_r <= 2'd0;
          num_r <= {34'b0, f_r.x_sum}; den_r <= 64'(f_r.area);
          rem_r <= '0; q_r <= '0; cnt_r <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= div_step(rem_sh, den_r);
          q_r <= {q_r[62:0], rem_sh >= den_r};
          num_r <= {num_r[62:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) st_r <= S_NEXT;
        end
        S_NEXT: begin
          rem_r <= '0; q_r <= '0; cnt_r <= '0;
          op_r <= op_r + 2'd1;
          case (op_r)
            2'd0: begin
              cx_r <= q_r[9:0];
              num_r <= {34'b0, f_r.y_sum};
              st_r <= S_DIV;
            end
            2'd1: begin
              cy_r <= q_r[9:0];
              num_r <= 64'({11'(f_r.x_max - f_r.x_min) + 11'd1, 8'b0});
              den_r <= 64'(11'(f_r.y_max - f_r.y_min) + 11'd1);
              st_r <= S_DIV;
            end
            2'd2: begin
              asp_r <= q_r[18:0];
              num_r <= 64'(an_r); den_r <= 64'(p2_r);
              st_r <= (p2_r == '0) ? S_OUT : S_DIV;
            end
            default: begin
              thin_r <= (q_r > 64'd65535) ? 16'hFFFF : q_r[15:0];
              st_r <= S_OUT;
            end
          endcase
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_object_area     = f_r.area;
  assign out_centroid_x      = cx_r;
  assign out_centroid_y      = cy_r;
  assign out_perimeter_count = f_r.perim;
  assign out_object_empty    = f_r.area == 21'd0;
  assign out_box_x_min       = out_object_empty ? 10'd0 : f_r.x_min;
  assign out_box_x_max       = out_object_empty ? 10'd0 : f_r.x_max;
  assign out_box_y_min       = out_object_empty ? 10'd0 : f_r.y_min;
  assign out_box_y_max       = out_object_empty ? 10'd0 : f_r.y_max;
  assign out_aspect_q8       = asp_r;
  assign out_thinness_q12    = thin_r;

endmodule

// File: src/object_shape_feature_extractor.sv
// Top level: configuration registers, pixel front end, queue, divider back end.
// Depends on osfe_pkg, osfe_front, osfe_queue, osfe_back.
//
//   channel  direction  handshake
//   in_*     input      in_valid / in_ready, one pixel per item
//   out_*    output     out_valid / out_ready, one result per frame
//   cfg_*    input      cfg_we, no wait
//
// Pixels are taken at one per cycle, except that the front end holds the input
// after each frame's last pixel until the queue has room and takes the totals.
// A non-empty frame result is offered after a multiply step and 64-step
// divisions for centroid x, centroid y, aspect and, for a non-zero perimeter,
// thinness. An empty frame result is offered the cycle after it is taken.
// Reset is synchronous, active low; line stores need no clearing.
module object_shape_feature_extractor import osfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_blue,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_object_area,
  output logic [9:0]  out_centroid_x,
  output logic [9:0]  out_centroid_y,
  output logic [20:0] out_perimeter_count,
  output logic [9:0]  out_box_x_min,
  output logic [9:0]  out_box_x_max,
  output logic [9:0]  out_box_y_min,
  output logic [9:0]  out_box_y_max,
  output logic [18:0] out_aspect_q8,
  output logic [15:0] out_thinness_q12,
  output logic        out_object_empty,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [7:0]  tb_r, tg_r, tr_r;
  logic [10:0] fw_r, fh_r;
  logic        fs_valid, fs_ready, q_valid, q_ready;
  frame_sum_t  fs_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r <= '0; tg_r <= '0; tr_r <= '0;
      fw_r <= 11'd640; fh_r <= 11'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLUE:   tb_r <= cfg_data[7:0];
        CFG_GREEN:  tg_r <= cfg_data[7:0];
        CFG_RED:    tr_r <= cfg_data[7:0];
        CFG_WIDTH:  fw_r <= cfg_data;
        CFG_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  osfe_front u_front (
    .clk, .rst_n,
    .px_valid(in_valid), .px_ready(in_ready),
    .px_blue(in_pixel_blue), .px_green(in_pixel_green), .px_red(in_pixel_red),
    .tgt_blue(tb_r), .tgt_green(tg_r), .tgt_red(tr_r),
    .cfg_w(fw_r), .cfg_h(fh_r),
    .sum_valid(fs_valid), .sum_ready(fs_ready), .sum_data(fs_data)
  );

  osfe_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fs_valid), .wr_ready(fs_ready), .wr_data(fs_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  osfe_back u_back (
    .clk, .rst_n,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid, .out_ready,
    .out_object_area, .out_centroid_x, .out_centroid_y, .out_perimeter_count,
    .out_box_x_min, .out_box_x_max, .out_box_y_min, .out_box_y_max,
    .out_aspect_q8, .out_thinness_q12, .out_object_empty
  );

endmodule
